/* rtl/sab_pkg.sv */
package sab_pkg;

	localparam int unsigned CRD_W = 32;
	localparam int unsigned EXT_W = 31;
	localparam int unsigned DIF_W = 34;
	localparam int unsigned MAG_W = 32;
	localparam int unsigned SQ_W  = 64;
	localparam int unsigned LEN_W = 33;
	localparam int unsigned FAC_W = 33;
	localparam int unsigned RT_STAGES = SQ_W / 2;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_SIZE_X   = 3'd3,
		REG_SIZE_Y   = 3'd4,
		REG_SIZE_Z   = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                        hit;
		logic                        in_box;
		logic [2:0]                  neg;
		logic [2:0][MAG_W-1:0]       mag;
		logic [SQ_W-1:0]             sq;
		logic [EXT_W-1:0]            rad;
		logic [CRD_W-1:0]            r;
	} sq_side_t;

	typedef struct packed {
		logic                        hit;
		logic                        norm;
		logic [2:0]                  neg;
		logic [2:0][MAG_W-1:0]       mag;
		logic [FAC_W-1:0]            f;
	} div_side_t;

endpackage

/* rtl/sab_front.sv */
module sab_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [sab_pkg::CRD_W-1:0]     sphere_x,
	input  logic [sab_pkg::CRD_W-1:0]     sphere_y,
	input  logic [sab_pkg::CRD_W-1:0]     sphere_z,
	input  logic [sab_pkg::EXT_W-1:0]     sphere_radius,
	input  logic [sab_pkg::EXT_W-1:0]     radius_scale,
	input  logic [sab_pkg::CRD_W-1:0]     contact_x,
	input  logic [sab_pkg::CRD_W-1:0]     contact_y,
	input  logic [sab_pkg::CRD_W-1:0]     contact_z,
	input  logic [sab_pkg::CRD_W-1:0]     box_cx,
	input  logic [sab_pkg::CRD_W-1:0]     box_cy,
	input  logic [sab_pkg::CRD_W-1:0]     box_cz,
	input  logic [sab_pkg::EXT_W-1:0]     box_sx,
	input  logic [sab_pkg::EXT_W-1:0]     box_sy,
	input  logic [sab_pkg::EXT_W-1:0]     box_sz,
	output logic                          out_valid,
	output sab_pkg::sq_side_t             out_side
);

	localparam int unsigned PRD_W = 2 * sab_pkg::EXT_W;

	logic [sab_pkg::CRD_W-1:0] s_in [3];
	logic [sab_pkg::CRD_W-1:0] c_in [3];
	logic [sab_pkg::CRD_W-1:0] p_in [3];
	logic [sab_pkg::EXT_W-1:0] e_in [3];

	assign s_in[0] = sphere_x;
	assign s_in[1] = sphere_y;
	assign s_in[2] = sphere_z;
	assign c_in[0] = box_cx;
	assign c_in[1] = box_cy;
	assign c_in[2] = box_cz;
	assign p_in[0] = contact_x;
	assign p_in[1] = contact_y;
	assign p_in[2] = contact_z;
	assign e_in[0] = box_sx;
	assign e_in[1] = box_sy;
	assign e_in[2] = box_sz;

	// stage 1: clamp to box, offsets
	logic [sab_pkg::DIF_W-1:0] d_c [3];
	logic [sab_pkg::CRD_W-1:0] v_c [3];

	always_comb begin
		logic signed [32:0] half, lo, hi, s33, c33, cl, dv;
		for (int i = 0; i < 3; i++) begin
			half = $signed({3'b000, e_in[i][30:1]});
			s33  = $signed({s_in[i][31], s_in[i]});
			c33  = $signed({c_in[i][31], c_in[i]});
			lo   = c33 - half;
			hi   = c33 + half;
			if (s33 < lo) begin
				cl = lo;
			end else if (s33 > hi) begin
				cl = hi;
			end else begin
				cl = s33;
			end
			d_c[i] = {s33[32], s33} - {cl[32], cl};
			dv = $signed({p_in[i][31], p_in[i]}) - s33;
			if (dv[32] != dv[31]) begin
				v_c[i] = dv[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end else begin
				v_c[i] = dv[31:0];
			end
		end
	end

	logic                      vld_s1;
	logic [sab_pkg::DIF_W-1:0] d_s1 [3];
	logic [sab_pkg::CRD_W-1:0] v_s1 [3];
	logic [PRD_W-1:0]          prod_s1;
	logic [sab_pkg::EXT_W-1:0] rad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= d_c[i];
				v_s1[i] <= v_c[i];
			end
			prod_s1 <= PRD_W'(sphere_radius) * PRD_W'(radius_scale);
			rad_s1  <= sphere_radius;
		end
	end

	// stage 2: magnitudes, scaled radius
	logic [PRD_W-1:0]          rsh;
	logic [sab_pkg::DIF_W-1:0] md_c [3];

	assign rsh = prod_s1 >> FRAC_BITS;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			md_c[i] = d_s1[i][sab_pkg::DIF_W-1] ? (~d_s1[i] + 1'b1) : d_s1[i];
		end
	end

	logic                      vld_s2;
	logic [sab_pkg::MAG_W-1:0] md_s2 [3];
	logic [2:0]                satd_s2;
	logic [2:0]                negd_s2;
	logic [sab_pkg::MAG_W-1:0] mv_s2 [3];
	logic [2:0]                negv_s2;
	logic                      inside_s2;
	logic [sab_pkg::CRD_W-1:0] r_s2;
	logic [sab_pkg::EXT_W-1:0] rad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				md_s2[i]   <= md_c[i][sab_pkg::MAG_W-1:0];
				satd_s2[i] <= |md_c[i][sab_pkg::DIF_W-1:sab_pkg::MAG_W];
				negd_s2[i] <= d_s1[i][sab_pkg::DIF_W-1];
				mv_s2[i]   <= v_s1[i][31] ? (~v_s1[i] + 1'b1) : v_s1[i];
				negv_s2[i] <= v_s1[i][31];
			end
			inside_s2 <= (d_s1[0] == '0) && (d_s1[1] == '0) && (d_s1[2] == '0);
			r_s2      <= (|rsh[PRD_W-1:sab_pkg::CRD_W]) ? '1 : rsh[sab_pkg::CRD_W-1:0];
			rad_s2    <= rad_s1;
		end
	end

	// stage 3: squares
	logic                      vld_s3;
	logic [sab_pkg::SQ_W-1:0]  sqd_s3 [3];
	logic [sab_pkg::SQ_W-1:0]  sqv_s3 [3];
	logic [sab_pkg::SQ_W-1:0]  rr_s3;
	logic [sab_pkg::MAG_W-1:0] md_s3 [3];
	logic [sab_pkg::MAG_W-1:0] mv_s3 [3];
	logic [2:0]                satd_s3;
	logic [2:0]                negd_s3;
	logic [2:0]                negv_s3;
	logic                      inside_s3;
	logic [sab_pkg::CRD_W-1:0] r_s3;
	logic [sab_pkg::EXT_W-1:0] rad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sqd_s3[i] <= sab_pkg::SQ_W'(md_s2[i]) * sab_pkg::SQ_W'(md_s2[i]);
				sqv_s3[i] <= sab_pkg::SQ_W'(mv_s2[i]) * sab_pkg::SQ_W'(mv_s2[i]);
				md_s3[i]  <= md_s2[i];
				mv_s3[i]  <= mv_s2[i];
			end
			rr_s3     <= sab_pkg::SQ_W'(r_s2) * sab_pkg::SQ_W'(r_s2);
			satd_s3   <= satd_s2;
			negd_s3   <= negd_s2;
			negv_s3   <= negv_s2;
			inside_s3 <= inside_s2;
			r_s3      <= r_s2;
			rad_s3    <= rad_s2;
		end
	end

	// stage 4: sums, saturating for the box distance
	logic [sab_pkg::SQ_W+1:0] d2sum;
	logic [sab_pkg::SQ_W+1:0] v2sum;

	assign d2sum = (sab_pkg::SQ_W+2)'(sqd_s3[0]) + (sab_pkg::SQ_W+2)'(sqd_s3[1])
		+ (sab_pkg::SQ_W+2)'(sqd_s3[2]);
	assign v2sum = (sab_pkg::SQ_W+2)'(sqv_s3[0]) + (sab_pkg::SQ_W+2)'(sqv_s3[1])
		+ (sab_pkg::SQ_W+2)'(sqv_s3[2]);

	logic                      vld_s4;
	logic [sab_pkg::SQ_W-1:0]  d2_s4;
	logic [sab_pkg::SQ_W-1:0]  v2_s4;
	logic [sab_pkg::SQ_W-1:0]  rr_s4;
	logic [sab_pkg::MAG_W-1:0] md_s4 [3];
	logic [sab_pkg::MAG_W-1:0] mv_s4 [3];
	logic [2:0]                negd_s4;
	logic [2:0]                negv_s4;
	logic                      inside_s4;
	logic [sab_pkg::CRD_W-1:0] r_s4;
	logic [sab_pkg::EXT_W-1:0] rad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d2_s4 <= ((|satd_s3) || (|d2sum[sab_pkg::SQ_W+1:sab_pkg::SQ_W])) ? '1
				: d2sum[sab_pkg::SQ_W-1:0];
			v2_s4 <= v2sum[sab_pkg::SQ_W-1:0];
			rr_s4 <= rr_s3;
			for (int i = 0; i < 3; i++) begin
				md_s4[i] <= md_s3[i];
				mv_s4[i] <= mv_s3[i];
			end
			negd_s4   <= negd_s3;
			negv_s4   <= negv_s3;
			inside_s4 <= inside_s3;
			r_s4      <= r_s3;
			rad_s4    <= rad_s3;
		end
	end

	// stage 5: hit test, select direction
	logic              vld_s5;
	sab_pkg::sq_side_t side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5.hit    <= d2_s4 <= rr_s4;
			side_s5.in_box <= inside_s4;
			side_s5.neg    <= inside_s4 ? negv_s4 : negd_s4;
			for (int i = 0; i < 3; i++) begin
				side_s5.mag[i] <= inside_s4 ? mv_s4[i] : md_s4[i];
			end
			side_s5.sq  <= inside_s4 ? v2_s4 : d2_s4;
			side_s5.rad <= rad_s4;
			side_s5.r   <= r_s4;
		end
	end

	assign out_valid = vld_s5;
	assign out_side  = side_s5;

endmodule

/* rtl/sab_sqrt.sv */
module sab_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  sab_pkg::sq_side_t             in_side,
	output logic                          out_valid,
	output sab_pkg::sq_side_t             out_side,
	output logic [sab_pkg::LEN_W-1:0]     out_root
);

	localparam int unsigned NS = sab_pkg::RT_STAGES;
	localparam int unsigned W  = sab_pkg::SQ_W;

	logic [W-1:0]      rem_s  [NS];
	logic [W-1:0]      res_s  [NS];
	logic              vld_s  [NS];
	sab_pkg::sq_side_t side_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stg
		localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);

		logic [W-1:0]      rem_i, res_i, t, rem_o, res_o;
		logic              vld_i;
		sab_pkg::sq_side_t side_i;

		if (k == 0) begin : g_first
			assign rem_i  = in_side.sq;
			assign res_i  = '0;
			assign vld_i  = in_valid;
			assign side_i = in_side;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign res_i  = res_s[k-1];
			assign vld_i  = vld_s[k-1];
			assign side_i = side_s[k-1];
		end

		always_comb begin
			t = res_i + BIT;
			if (rem_i >= t) begin
				rem_o = rem_i - t;
				res_o = (res_i >> 1) + BIT;
			end else begin
				rem_o = rem_i;
				res_o = res_i >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_o;
				res_s[k]  <= res_o;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_side  = side_s[NS-1];
	assign out_root  = res_s[NS-1][sab_pkg::LEN_W-1:0];

endmodule

/* rtl/sab_div.sv */
module sab_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  sab_pkg::div_side_t            in_side,
	input  logic [sab_pkg::LEN_W-1:0]     in_len,
	output logic                          out_valid,
	output sab_pkg::div_side_t            out_side,
	output logic [2:0][FRAC_BITS:0]       out_quo
);

	localparam int unsigned NS = FRAC_BITS + 1;
	localparam int unsigned RW = sab_pkg::LEN_W + FRAC_BITS;

	logic [2:0][RW-1:0]          rem_s  [NS];
	logic [2:0][FRAC_BITS:0]     quo_s  [NS];
	logic [sab_pkg::LEN_W-1:0]   len_s  [NS];
	logic                        vld_s  [NS];
	sab_pkg::div_side_t          side_s [NS];

	for (genvar k = 0; k < NS; k++) begin : g_stg
		localparam int unsigned J = FRAC_BITS - k;

		logic [2:0][RW-1:0]        rem_i, rem_o;
		logic [2:0][FRAC_BITS:0]   quo_i, quo_o;
		logic [sab_pkg::LEN_W-1:0] len_i;
		logic [RW-1:0]             sub;
		logic                      vld_i;
		sab_pkg::div_side_t        side_i;

		if (k == 0) begin : g_first
			for (genvar l = 0; l < 3; l++) begin : g_lane
				assign rem_i[l] = {1'b0, in_side.mag[l], {FRAC_BITS{1'b0}}};
			end
			assign quo_i  = '0;
			assign len_i  = in_len;
			assign vld_i  = in_valid;
			assign side_i = in_side;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign len_i  = len_s[k-1];
			assign vld_i  = vld_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign sub = RW'(len_i) << J;

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				if (rem_i[l] >= sub) begin
					rem_o[l] = rem_i[l] - sub;
					quo_o[l] = quo_i[l] | ((FRAC_BITS+1)'(1) << J);
				end else begin
					rem_o[l] = rem_i[l];
					quo_o[l] = quo_i[l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_o;
				quo_s[k]  <= quo_o;
				len_s[k]  <= len_i;
				side_s[k] <= side_i;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_side  = side_s[NS-1];
	assign out_quo   = quo_s[NS-1];

endmodule

/* rtl/sphere_aabb_push.sv */
// Sphere against axis-aligned box, signed fixed point with FRAC_BITS fraction bits.
// Write the box center and full extents through the cfg port while no sphere is in
// flight. One sphere beat is taken every cycle while sphere_stall is low; each
// result passes through five front stages, a 32-stage square root, one stage to
// form the push length, a FRAC_BITS + 1 stage divider for the three normalized
// components, one multiply stage and the output register; Q16.16 by default.
// push_stall with push_valid high holds the whole pipeline and raises sphere_stall.
// hit is 0 and push is zero on a miss; push saturates to the signed 32-bit range.
module sphere_aabb_push #(
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sab_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sab_pkg::CRD_W-1:0]         cfg_data,
	input  logic                              sphere_valid,
	output logic                              sphere_stall,
	input  logic [sab_pkg::CRD_W-1:0]         sphere_x,
	input  logic [sab_pkg::CRD_W-1:0]         sphere_y,
	input  logic [sab_pkg::CRD_W-1:0]         sphere_z,
	input  logic [sab_pkg::EXT_W-1:0]         sphere_radius,
	input  logic [sab_pkg::EXT_W-1:0]         radius_scale,
	input  logic [sab_pkg::CRD_W-1:0]         contact_x,
	input  logic [sab_pkg::CRD_W-1:0]         contact_y,
	input  logic [sab_pkg::CRD_W-1:0]         contact_z,
	output logic                              push_valid,
	input  logic                              push_stall,
	output logic                              hit,
	output logic [sab_pkg::CRD_W-1:0]         push_x,
	output logic [sab_pkg::CRD_W-1:0]         push_y,
	output logic [sab_pkg::CRD_W-1:0]         push_z
);

	localparam logic [sab_pkg::SQ_W-1:0] ONE_SQ = sab_pkg::SQ_W'(1) << (2 * FRAC_BITS);
	localparam int unsigned PW = sab_pkg::FAC_W + 1;
	localparam int unsigned MW = FRAC_BITS + 1 + sab_pkg::FAC_W;

	logic en;

	assign en           = !(push_valid && push_stall);
	assign sphere_stall = !en;
	assign cfg_ready    = 1'b1;

	logic [sab_pkg::CRD_W-1:0] box_cx_q, box_cy_q, box_cz_q;
	logic [sab_pkg::EXT_W-1:0] box_sx_q, box_sy_q, box_sz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_cx_q <= '0;
			box_cy_q <= '0;
			box_cz_q <= '0;
			box_sx_q <= '0;
			box_sy_q <= '0;
			box_sz_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (sab_pkg::cfg_reg_t'(cfg_index))
				sab_pkg::REG_CENTER_X: box_cx_q <= cfg_data;
				sab_pkg::REG_CENTER_Y: box_cy_q <= cfg_data;
				sab_pkg::REG_CENTER_Z: box_cz_q <= cfg_data;
				sab_pkg::REG_SIZE_X:   box_sx_q <= cfg_data[sab_pkg::EXT_W-1:0];
				sab_pkg::REG_SIZE_Y:   box_sy_q <= cfg_data[sab_pkg::EXT_W-1:0];
				sab_pkg::REG_SIZE_Z:   box_sz_q <= cfg_data[sab_pkg::EXT_W-1:0];
				default: ;
			endcase
		end
	end

	logic              fr_valid;
	sab_pkg::sq_side_t fr_side;

	sab_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (sphere_valid),
		.sphere_x      (sphere_x),
		.sphere_y      (sphere_y),
		.sphere_z      (sphere_z),
		.sphere_radius (sphere_radius),
		.radius_scale  (radius_scale),
		.contact_x     (contact_x),
		.contact_y     (contact_y),
		.contact_z     (contact_z),
		.box_cx        (box_cx_q),
		.box_cy        (box_cy_q),
		.box_cz        (box_cz_q),
		.box_sx        (box_sx_q),
		.box_sy        (box_sy_q),
		.box_sz        (box_sz_q),
		.out_valid     (fr_valid),
		.out_side      (fr_side)
	);

	logic                      rt_valid;
	sab_pkg::sq_side_t         rt_side;
	logic [sab_pkg::LEN_W-1:0] rt_root;

	sab_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_side   (fr_side),
		.out_valid (rt_valid),
		.out_side  (rt_side),
		.out_root  (rt_root)
	);

	// push length and normalize flag
	logic [sab_pkg::FAC_W-1:0] f_c;

	always_comb begin
		if (rt_side.in_box) begin
			f_c = rt_root + sab_pkg::FAC_W'(rt_side.rad);
		end else if (sab_pkg::LEN_W'(rt_side.r) >= rt_root) begin
			f_c = sab_pkg::LEN_W'(rt_side.r) - rt_root;
		end else begin
			f_c = '0;
		end
	end

	logic                      vld_p;
	sab_pkg::div_side_t        side_p;
	logic [sab_pkg::LEN_W-1:0] len_p;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p <= 1'b0;
		end else if (en) begin
			vld_p <= rt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_p.hit  <= rt_side.hit;
			side_p.norm <= rt_side.sq > ONE_SQ;
			side_p.neg  <= rt_side.neg;
			side_p.mag  <= rt_side.mag;
			side_p.f    <= f_c;
			len_p       <= rt_root;
		end
	end

	logic                    dv_valid;
	sab_pkg::div_side_t      dv_side;
	logic [2:0][FRAC_BITS:0] dv_quo;

	sab_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_p),
		.in_side   (side_p),
		.in_len    (len_p),
		.out_valid (dv_valid),
		.out_side  (dv_side),
		.out_quo   (dv_quo)
	);

	// scale to push length
	logic [FRAC_BITS:0] op_c [3];
	logic [MW-1:0]      mul_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			op_c[i]  = dv_side.norm ? dv_quo[i] : dv_side.mag[i][FRAC_BITS:0];
			mul_c[i] = MW'(op_c[i]) * MW'(dv_side.f);
		end
	end

	logic          vld_m;
	logic [PW-1:0] p_m [3];
	logic [2:0]    neg_m;
	logic          hit_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m <= 1'b0;
		end else if (en) begin
			vld_m <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_m[i] <= PW'(mul_c[i] >> FRAC_BITS);
			end
			neg_m <= dv_side.neg;
			hit_m <= dv_side.hit;
		end
	end

	// sign, saturate, zero on miss
	logic [sab_pkg::CRD_W-1:0] push_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!hit_m) begin
				push_c[i] = '0;
			end else if (neg_m[i]) begin
				push_c[i] = (p_m[i] > PW'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
					: sab_pkg::CRD_W'(~p_m[i] + 1'b1);
			end else begin
				push_c[i] = (p_m[i] > PW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
					: p_m[i][sab_pkg::CRD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_valid <= 1'b0;
		end else if (en) begin
			push_valid <= vld_m;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit    <= hit_m;
			push_x <= push_c[0];
			push_y <= push_c[1];
			push_z <= push_c[2];
		end
	end

endmodule
